### hw/rtl/rpkh_pkg.sv
// Shared types and constants for the rotated point key hit test block.
package rpkh_pkg;

    localparam int KEYS_DEFAULT = 32;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_ORIGIN_X       = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y       = 3'd1;
    localparam logic [2:0] CFG_COS_ANGLE      = 3'd2;
    localparam logic [2:0] CFG_SIN_ANGLE      = 3'd3;
    localparam logic [2:0] CFG_VIRTUAL_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_VIRTUAL_HEIGHT = 3'd5;

    localparam logic [0:0] OP_LOAD  = 1'b0;
    localparam logic [0:0] OP_QUERY = 1'b1;

    localparam logic signed [15:0] Q14_ONE = 16'sd16384;

    // floor(p / 10000) == (p * PCT_RECIP) >> PCT_SHIFT for any 25 bit p
    localparam int PCT_SHIFT = 39;
    localparam logic [25:0] PCT_RECIP = 26'd54975582;
    localparam logic [10:0] CENTER_MAX = 11'd2047;

    typedef struct packed {
        logic [0:0]  operation;
        logic [4:0]  entry_index;
        logic [13:0] key_pos_x_pct;
        logic [13:0] key_pos_y_pct;
        logic [9:0]  key_half_width;
        logic [9:0]  key_half_height;
        logic [7:0]  key_code;
        logic [0:0]  key_is_modifier;
        logic [9:0]  point_x;
        logic [9:0]  point_y;
    } item_t;

    typedef struct packed {
        logic [0:0]         hit;
        logic [4:0]         key_number;
        logic [7:0]         hit_key_code;
        logic [0:0]         hit_modifier;
        logic signed [11:0] rotated_x;
        logic signed [11:0] rotated_y;
    } result_t;

    typedef struct packed {
        logic [9:0]         origin_x;
        logic [9:0]         origin_y;
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic [10:0]        virtual_width;
        logic [10:0]        virtual_height;
    } cfg_t;

    typedef struct packed {
        logic [10:0] cx;
        logic [10:0] cy;
        logic [9:0]  hw;
        logic [9:0]  hh;
        logic [7:0]  code;
        logic [0:0]  modifier;
    } key_entry_t;

    typedef struct packed {
        logic       en;
        key_entry_t entry;
    } tbl_wr_t;

    typedef struct packed {
        logic       valid;
        key_entry_t entry;
    } tbl_rd_t;

endpackage

### hw/rtl/rpkh_scale.sv
// Percentage to pixel scaling of one key centre coordinate, two register stages.
module rpkh_scale
    import rpkh_pkg::*;
(
    input  logic        clk,
    input  logic [13:0] pct,
    input  logic [10:0] size,
    output logic [10:0] center
);

    logic [24:0] prod_reg;
    logic [50:0] quot_reg;
    logic [11:0] quot;

    always_ff @(posedge clk)
    begin
        prod_reg <= 25'(pct) * 25'(size);
        quot_reg <= 51'(prod_reg) * 51'(PCT_RECIP);
    end

    assign quot   = quot_reg[PCT_SHIFT +: 12];
    assign center = (quot > 12'(CENTER_MAX)) ? CENTER_MAX : quot[10:0];

endmodule

### hw/rtl/rpkh_rotate.sv
// Translation and Q1.14 rotation of the query point, two register stages.
module rpkh_rotate
    import rpkh_pkg::*;
(
    input  logic               clk,
    input  logic [9:0]         point_x,
    input  logic [9:0]         point_y,
    input  cfg_t               cfg,
    output logic signed [11:0] rot_x,
    output logic signed [11:0] rot_y
);

    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic signed [26:0] xc_reg;
    logic signed [26:0] ys_reg;
    logic signed [26:0] yc_reg;
    logic signed [26:0] xs_reg;
    logic signed [27:0] sum_x;
    logic signed [27:0] sum_y;
    logic signed [11:0] rot_x_reg;
    logic signed [11:0] rot_y_reg;

    function automatic logic signed [11:0] trunc_sat(input logic signed [27:0] s);
        logic signed [27:0] biased;
        logic signed [13:0] q;
        biased = s + ((s < 0) ? 28'sd16383 : 28'sd0);
        q      = 14'(biased >>> 14);
        if (q > 14'sd2047)
            return 12'sd2047;
        else if (q < -14'sd2048)
            return -12'sd2048;
        else
            return q[11:0];
    endfunction

    assign dx = $signed({1'b0, point_x}) - $signed({1'b0, cfg.origin_x});
    assign dy = $signed({1'b0, point_y}) - $signed({1'b0, cfg.origin_y});

    always_ff @(posedge clk)
    begin
        xc_reg <= 27'(dx) * 27'(cfg.cos_angle);
        ys_reg <= 27'(dy) * 27'(cfg.sin_angle);
        yc_reg <= 27'(dy) * 27'(cfg.cos_angle);
        xs_reg <= 27'(dx) * 27'(cfg.sin_angle);
    end

    assign sum_x = 28'(xc_reg) + 28'(ys_reg);
    assign sum_y = 28'(yc_reg) - 28'(xs_reg);

    always_ff @(posedge clk)
    begin
        rot_x_reg <= trunc_sat(sum_x);
        rot_y_reg <= trunc_sat(sum_y);
    end

    assign rot_x = rot_x_reg;
    assign rot_y = rot_y_reg;

endmodule

### hw/rtl/rpkh_table.sv
// Key table memory with registered read port and per-entry valid bits.
module rpkh_table
    import rpkh_pkg::*;
#(
    parameter int KEYS = KEYS_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tbl_wr_t                                wr,
    input  logic [((KEYS > 1) ? $clog2(KEYS) : 1)-1:0] wr_addr,
    input  logic [((KEYS > 1) ? $clog2(KEYS) : 1)-1:0] rd_addr,
    output tbl_rd_t                                rd
);

    key_entry_t mem [KEYS];
    key_entry_t rd_entry_reg;
    logic [KEYS-1:0] valid_reg;
    logic            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr_addr] <= wr.entry;
        rd_entry_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
                valid_reg[wr_addr] <= 1'b1;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.entry = rd_entry_reg;

endmodule

### hw/rtl/rotated_point_key_hit_test_core.sv
// Rotated point key hit test: top level with control sequencer and registers.
// A load word passes through two multiply stages that scale the key
// centre, then the entry is written to the table memory. A query word
// rotates the point, then scans the entries in order up to the first
// match, or through all KEYS entries when nothing matches; the table
// memory's single read port delivers one entry a cycle to the box compare.
// Input words are stalled until the current word is finished. A finished
// result sits in an output register, so the next word is taken while it
// waits. The configuration port is always ready.
module rotated_point_key_hit_test_core
    import rpkh_pkg::*;
#(
    parameter int KEYS = KEYS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int KEY_IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam logic [KEY_IDX_W-1:0] LAST_KEY = KEY_IDX_W'(KEYS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD_A = 3'd1;
    localparam logic [2:0] S_LOAD_B = 3'd2;
    localparam logic [2:0] S_LOAD_W = 3'd3;
    localparam logic [2:0] S_ROT_A  = 3'd4;
    localparam logic [2:0] S_ROT_B  = 3'd5;
    localparam logic [2:0] S_SCAN   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    item_t                item_reg;
    cfg_t                 cfg_reg;
    logic [KEY_IDX_W-1:0] cnt_reg;
    logic [KEY_IDX_W-1:0] cnt_next;
    logic [KEY_IDX_W-1:0] cmp_idx_reg;
    result_t              hold_reg;
    result_t              hold_next;
    result_t              out_reg;
    logic                 out_valid_reg;

    logic [10:0]          center_x;
    logic [10:0]          center_y;
    logic signed [11:0]   rot_x;
    logic signed [11:0]   rot_y;
    tbl_wr_t              tbl_wr;
    tbl_rd_t              tbl_rd;

    logic                 accept;
    logic                 out_free;
    logic                 load_ok;
    logic signed [12:0]   x_lo;
    logic signed [12:0]   x_hi;
    logic signed [12:0]   y_lo;
    logic signed [12:0]   y_hi;
    logic signed [12:0]   rx13;
    logic signed [12:0]   ry13;
    logic                 match;

    rpkh_scale u_scale_x (
        .clk    (clk),
        .pct    (item_reg.key_pos_x_pct),
        .size   (cfg_reg.virtual_width),
        .center (center_x)
    );

    rpkh_scale u_scale_y (
        .clk    (clk),
        .pct    (item_reg.key_pos_y_pct),
        .size   (cfg_reg.virtual_height),
        .center (center_y)
    );

    rpkh_rotate u_rotate (
        .clk     (clk),
        .point_x (item_reg.point_x),
        .point_y (item_reg.point_y),
        .cfg     (cfg_reg),
        .rot_x   (rot_x),
        .rot_y   (rot_y)
    );

    rpkh_table #(
        .KEYS (KEYS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .wr_addr (KEY_IDX_W'(item_reg.entry_index)),
        .rd_addr (cnt_reg),
        .rd      (tbl_rd)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    assign load_ok         = int'(item_reg.entry_index) < KEYS;
    assign tbl_wr.en       = (state_reg == S_LOAD_W) && load_ok;
    assign tbl_wr.entry    = '{cx: center_x, cy: center_y,
                               hw: item_reg.key_half_width,
                               hh: item_reg.key_half_height,
                               code: item_reg.key_code,
                               modifier: item_reg.key_is_modifier};

    // box test, edges inclusive
    assign x_lo  = $signed({2'b00, tbl_rd.entry.cx}) - $signed({3'b000, tbl_rd.entry.hw});
    assign x_hi  = $signed({2'b00, tbl_rd.entry.cx}) + $signed({3'b000, tbl_rd.entry.hw});
    assign y_lo  = $signed({2'b00, tbl_rd.entry.cy}) - $signed({3'b000, tbl_rd.entry.hh});
    assign y_hi  = $signed({2'b00, tbl_rd.entry.cy}) + $signed({3'b000, tbl_rd.entry.hh});
    assign rx13  = 13'(rot_x);
    assign ry13  = 13'(rot_y);
    assign match = tbl_rd.valid && (rx13 >= x_lo) && (rx13 <= x_hi)
                   && (ry13 >= y_lo) && (ry13 <= y_hi);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hold_next  = hold_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (item.operation == OP_QUERY) ? S_ROT_A : S_LOAD_A;
                cnt_next = '0;
            end
            S_LOAD_A: state_next = S_LOAD_B;
            S_LOAD_B: state_next = S_LOAD_W;
            S_LOAD_W: state_next = S_IDLE;
            S_ROT_A:  state_next = S_ROT_B;
            S_ROT_B:
            begin
                state_next = S_SCAN;
                if (cnt_reg != LAST_KEY)
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SCAN:
            begin
                hold_next.rotated_x = rot_x;
                hold_next.rotated_y = rot_y;
                if (match)
                begin
                    hold_next.hit          = 1'b1;
                    hold_next.key_number   = 5'(cmp_idx_reg);
                    hold_next.hit_key_code = tbl_rd.entry.code;
                    hold_next.hit_modifier = tbl_rd.entry.modifier;
                    state_next             = S_DONE;
                end
                else if (cmp_idx_reg == LAST_KEY)
                begin
                    hold_next.hit          = 1'b0;
                    hold_next.key_number   = '0;
                    hold_next.hit_key_code = '0;
                    hold_next.hit_modifier = 1'b0;
                    state_next             = S_DONE;
                end
                else if (cnt_reg != LAST_KEY)
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            cfg_reg       <= '{origin_x: '0, origin_y: '0, cos_angle: Q14_ONE,
                               sin_angle: '0, virtual_width: '0,
                               virtual_height: '0};
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X:       cfg_reg.origin_x       <= cfg_data[9:0];
                    CFG_ORIGIN_Y:       cfg_reg.origin_y       <= cfg_data[9:0];
                    CFG_COS_ANGLE:      cfg_reg.cos_angle      <= $signed(cfg_data);
                    CFG_SIN_ANGLE:      cfg_reg.sin_angle      <= $signed(cfg_data);
                    CFG_VIRTUAL_WIDTH:  cfg_reg.virtual_width  <= cfg_data[10:0];
                    CFG_VIRTUAL_HEIGHT: cfg_reg.virtual_height <= cfg_data[10:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        cmp_idx_reg <= cnt_reg;
        hold_reg    <= hold_next;
        if (state_reg == S_DONE && out_free)
            out_reg <= hold_reg;
    end

endmodule

### test/rotated_point_key_hit_test_core_test.sv
// Self-checking testbench for the rotated point key hit test core.
module rotated_point_key_hit_test_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rpkh_pkg::*;

    localparam int KEY_COUNT = KEYS_DEFAULT;
    localparam int PCT_FULL = 10000;
    localparam int PHASES = 8;
    localparam int PHASE_WORDS = 172;
    localparam int LONG_HOLD = 400;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predictor state
    cfg_t                   regs;
    key_entry_t             key_store [KEY_COUNT];
    logic [KEY_COUNT-1:0]   key_loaded = '0;
    result_t                hits_due [$];
    item_t                  words_to_send [$];

    bit          idle_on = 1'b1;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          holds_asked = 0;
    int          holds_done = 0;
    int          bad_words = 0;
    int unsigned cycle_count = 0;

    rotated_point_key_hit_test_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [10:0] scale_pct(input logic [13:0] pct, input logic [10:0] span);
        int unsigned v;
        v = 32'(pct);
        v = v * 32'(span) / PCT_FULL;
        return (v > CENTER_MAX) ? CENTER_MAX : v[10:0];
    endfunction

    function automatic logic signed [11:0] clip12(input longint v);
        if (v > 2047)
            return 12'h7FF;
        if (v < -2048)
            return 12'h800;
        return v[11:0];
    endfunction

    function automatic logic [9:0] clamp_pixel(input longint v);
        if (v < 0)
            return 10'd0;
        if (v > 1023)
            return 10'd1023;
        return v[9:0];
    endfunction

    function automatic item_t noise_word();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic void predict_word(input item_t w);
        longint px, py, ox, oy, cs, sn, dx, dy;
        logic signed [11:0] rx, ry;
        int rxi, ryi, cx, cy, hw, hh;
        result_t r;
        if (w.operation == OP_LOAD)
        begin
            if (w.entry_index < KEY_COUNT)
            begin
                key_store[w.entry_index].cx = scale_pct(w.key_pos_x_pct, regs.virtual_width);
                key_store[w.entry_index].cy = scale_pct(w.key_pos_y_pct, regs.virtual_height);
                key_store[w.entry_index].hw = w.key_half_width;
                key_store[w.entry_index].hh = w.key_half_height;
                key_store[w.entry_index].code = w.key_code;
                key_store[w.entry_index].modifier = w.key_is_modifier;
                key_loaded[w.entry_index] = 1'b1;
            end
            return;
        end
        px = longint'(w.point_x);
        py = longint'(w.point_y);
        ox = longint'(regs.origin_x);
        oy = longint'(regs.origin_y);
        cs = longint'(regs.cos_angle);
        sn = longint'(regs.sin_angle);
        dx = px - ox;
        dy = py - oy;
        rx = clip12((dx * cs + dy * sn) / Q14_ONE);
        ry = clip12((dy * cs - dx * sn) / Q14_ONE);
        rxi = int'(rx);
        ryi = int'(ry);
        r = '0;
        r.rotated_x = rx;
        r.rotated_y = ry;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            cx = int'(key_store[k].cx);
            cy = int'(key_store[k].cy);
            hw = int'(key_store[k].hw);
            hh = int'(key_store[k].hh);
            if (!r.hit && key_loaded[k] && rxi >= cx - hw && rxi <= cx + hw
                && ryi >= cy - hh && ryi <= cy + hh)
            begin
                r.hit = 1'b1;
                r.key_number = 5'(k);
                r.hit_key_code = key_store[k].code;
                r.hit_modifier = key_store[k].modifier;
            end
        end
        hits_due.push_back(r);
    endfunction

    function automatic item_t load_word(input logic [4:0] idx, input logic [13:0] xp, yp,
                                        input logic [9:0] hw, hh, input logic [7:0] code,
                                        input logic modifier);
        item_t w;
        w = noise_word();
        w.operation = OP_LOAD;
        w.entry_index = idx;
        w.key_pos_x_pct = xp;
        w.key_pos_y_pct = yp;
        w.key_half_width = hw;
        w.key_half_height = hh;
        w.key_code = code;
        w.key_is_modifier = modifier;
        return w;
    endfunction

    function automatic item_t query_word(input logic [9:0] x, y);
        item_t w;
        w = noise_word();
        w.operation = OP_QUERY;
        w.point_x = x;
        w.point_y = y;
        return w;
    endfunction

    function automatic item_t random_word(input bit want_load);
        item_t w;
        int k, hw, hh, jx, jy;
        longint tx, ty, cs, sn, ox, oy;
        w = noise_word();
        if (want_load)
        begin
            w.operation = OP_LOAD;
            if ($urandom_range(0, 6) != 0)
            begin
                w.key_pos_x_pct = 14'($urandom_range(0, PCT_FULL));
                w.key_pos_y_pct = 14'($urandom_range(0, PCT_FULL));
            end
            if ($urandom_range(0, 7) != 0)
            begin
                w.key_half_width = 10'($urandom_range(0, 90));
                w.key_half_height = 10'($urandom_range(0, 90));
            end
            return w;
        end
        w.operation = OP_QUERY;
        k = int'($urandom_range(0, KEY_COUNT - 1));
        if ($urandom_range(0, 9) < 7 && key_loaded[k])
        begin
            // aim at the key: undo the rotation about the origin for a point at its centre plus a small offset
            hw = int'(key_store[k].hw);
            hh = int'(key_store[k].hh);
            jx = int'($urandom_range(0, 2 * hw + 4));
            jy = int'($urandom_range(0, 2 * hh + 4));
            tx = longint'(key_store[k].cx);
            ty = longint'(key_store[k].cy);
            tx = tx + jx - hw - 2;
            ty = ty + jy - hh - 2;
            cs = longint'(regs.cos_angle);
            sn = longint'(regs.sin_angle);
            ox = longint'(regs.origin_x);
            oy = longint'(regs.origin_y);
            w.point_x = clamp_pixel(ox + (tx * cs - ty * sn) / Q14_ONE);
            w.point_y = clamp_pixel(oy + (tx * sn + ty * cs) / Q14_ONE);
        end
        return w;
    endfunction

    // call just after a rising edge; leaves cfg_valid high
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ORIGIN_X:       regs.origin_x = data[9:0];
            CFG_ORIGIN_Y:       regs.origin_y = data[9:0];
            CFG_COS_ANGLE:      regs.cos_angle = data;
            CFG_SIN_ANGLE:      regs.sin_angle = data;
            CFG_VIRTUAL_WIDTH:  regs.virtual_width = data[10:0];
            CFG_VIRTUAL_HEIGHT: regs.virtual_height = data[10:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input cfg_t v, input bit spares);
        logic [15:0] junk;
        junk = 16'($urandom);
        @(posedge clk);
        write_reg(CFG_ORIGIN_X, {junk[15:10], v.origin_x});
        write_reg(CFG_ORIGIN_Y, {junk[5:0], v.origin_y});
        write_reg(CFG_COS_ANGLE, v.cos_angle);
        write_reg(CFG_SIN_ANGLE, v.sin_angle);
        write_reg(CFG_VIRTUAL_WIDTH, {junk[15:11], v.virtual_width});
        write_reg(CFG_VIRTUAL_HEIGHT, {junk[4:0], v.virtual_height});
        if (spares)
        begin
            write_reg(CFG_SPARE_LO, 16'($urandom));
            write_reg(CFG_SPARE_HI, 16'($urandom));
        end
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain;
        do
            @(negedge clk);
        while (words_to_send.size() != 0 || item_valid || hits_due.size() != 0);
        repeat (12) @(negedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predict_word(item);
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    item_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 7) == 0)
                begin
                    gap_left <= int'($urandom_range(0, 9));
                    item_valid <= 1'b0;
                end
                else if (words_to_send.size() != 0)
                begin
                    item <= words_to_send.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done <= holds_asked;
            hold_left <= LONG_HOLD;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= int'($urandom_range(0, 9));
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (hits_due.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display({"unexpected result word: ",
                              "hit=%0d key=%0d code=%0h mod=%0d x=%0d y=%0d"},
                             result.hit, result.key_number, result.hit_key_code,
                             result.hit_modifier, result.rotated_x, result.rotated_y);
            end
            else
            begin
                want = hits_due.pop_front();
                if (result.hit !== want.hit || result.key_number !== want.key_number
                    || result.hit_key_code !== want.hit_key_code
                    || result.hit_modifier !== want.hit_modifier
                    || result.rotated_x !== want.rotated_x
                    || result.rotated_y !== want.rotated_y)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display({"mismatch: got hit=%0d key=%0d code=%0h mod=%0d x=%0d y=%0d, ",
                                  "wanted hit=%0d key=%0d code=%0h mod=%0d x=%0d y=%0d"},
                                 result.hit, result.key_number, result.hit_key_code,
                                 result.hit_modifier, result.rotated_x, result.rotated_y,
                                 want.hit, want.key_number, want.hit_key_code,
                                 want.hit_modifier, want.rotated_x, want.rotated_y);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        cfg_t next;
        real angle;
        regs.origin_x = 10'd0;
        regs.origin_y = 10'd0;
        regs.cos_angle = Q14_ONE;
        regs.sin_angle = 16'sd0;
        regs.virtual_width = 11'd0;
        regs.virtual_height = 11'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: empty table, identity rotation, zero keyboard size
        words_to_send.push_back(query_word(10'd0, 10'd0));
        words_to_send.push_back(load_word(5'd0, 14'd10000, 14'd10000, 10'd0, 10'd0, 8'hA5, 1'b1));
        words_to_send.push_back(query_word(10'd0, 10'd0));
        words_to_send.push_back(query_word(10'd1, 10'd0));
        drain();

        // box edges, overlapping keys, centre saturation, field extremes
        next = regs;
        next.virtual_width = 11'd2047;
        next.virtual_height = 11'd1000;
        set_regs(next, 1'b0);
        words_to_send.push_back(load_word(5'd31, 14'd16383, 14'd0, 10'd1023, 10'd1023,
                                          8'hFF, 1'b1));
        words_to_send.push_back(load_word(5'd5, 14'd2443, 14'd5000, 10'd10, 10'd20, 8'h3C, 1'b0));
        words_to_send.push_back(load_word(5'd6, 14'd2443, 14'd5000, 10'd100, 10'd100,
                                          8'h77, 1'b1));
        words_to_send.push_back(query_word(10'd490, 10'd480));
        words_to_send.push_back(query_word(10'd510, 10'd520));
        words_to_send.push_back(query_word(10'd511, 10'd500));
        words_to_send.push_back(query_word(10'd489, 10'd479));
        words_to_send.push_back(query_word(10'd1023, 10'd1023));
        words_to_send.push_back(load_word(5'd31, 14'd0, 14'd16383, 10'd0, 10'd1023, 8'h00, 1'b0));
        words_to_send.push_back(query_word(10'd0, 10'd1023));
        drain();

        // out-of-range angles: saturation of the rotated point and truncation toward zero
        next = regs;
        next.cos_angle = 16'sh8000;
        next.sin_angle = 16'sh8000;
        set_regs(next, 1'b0);
        words_to_send.push_back(query_word(10'd1023, 10'd1023));
        words_to_send.push_back(query_word(10'd1023, 10'd0));
        drain();

        next.origin_x = 10'd1023;
        next.origin_y = 10'd1023;
        next.cos_angle = 16'sh7FFF;
        next.sin_angle = 16'sh8000;
        set_regs(next, 1'b1);
        words_to_send.push_back(query_word(10'd0, 10'd0));
        words_to_send.push_back(query_word(10'd0, 10'd1023));

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            next.origin_x = 10'($urandom_range(0, 1023));
            next.origin_y = 10'($urandom_range(0, 1023));
            next.virtual_width = 11'($urandom_range(0, 2047));
            next.virtual_height = 11'($urandom_range(0, 2047));
            if (p % 4 == 3)
            begin
                next.cos_angle = 16'($urandom);
                next.sin_angle = 16'($urandom);
            end
            else
            begin
                angle = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
                next.cos_angle = 16'($rtoi(16384.0 * $cos(angle)));
                next.sin_angle = 16'($rtoi(16384.0 * $sin(angle)));
            end
            if (p == 0)
            begin
                next.origin_x = 10'd1023;
                next.origin_y = 10'd1023;
                next.cos_angle = Q14_ONE;
                next.sin_angle = 16'sd0;
                next.virtual_width = 11'd2047;
                next.virtual_height = 11'd2047;
            end
            else if (p == 2)
            begin
                next.origin_x = 10'd0;
                next.origin_y = 10'd0;
                next.virtual_width = 11'd0;
            end
            idle_on = (p != 4 && p != PHASES - 1);
            set_regs(next, p == 5);
            if (p == 1 || p == 5)
                holds_asked++;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                while (words_to_send.size() >= 4)
                    @(negedge clk);
                words_to_send.push_back(random_word(n < 12 || $urandom_range(0, 4) == 0));
                if (p == 3 && n == PHASE_WORDS / 2)
                    drain();
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (bad_words == 0 && hits_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rpkh_pkg.sv
hw/rtl/rpkh_scale.sv
hw/rtl/rpkh_rotate.sv
hw/rtl/rpkh_table.sv
hw/rtl/rotated_point_key_hit_test_core.sv
test/rotated_point_key_hit_test_core_test.sv
